// ===== rtl/utf8d_pkg.sv =====
// Shared types and constants for the 31-bit legacy UTF-8 decoder.
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned BatchW = 16;
  localparam int unsigned LeftW  = 3;

  // Continuation payload mask
  localparam logic [ByteW-1:0] ContMask = 8'h3F;

  // Lead byte classes
  typedef enum logic [2:0] {
    LeadAscii,
    LeadTwo,
    LeadThree,
    LeadFour,
    LeadFive,
    LeadSix,
    LeadBad
  } lead_kind_e;

  // One decoded character between the front and the back
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           decode_error;
  } char_t;

  // Classify a byte in lead position
  function automatic lead_kind_e classify_lead(input logic [ByteW-1:0] b);
    lead_kind_e kind;
    if ((b & 8'h80) == 8'h00) begin
      kind = LeadAscii;
    end else if ((b & 8'hE0) == 8'hC0) begin
      kind = LeadTwo;
    end else if ((b & 8'hF0) == 8'hE0) begin
      kind = LeadThree;
    end else if ((b & 8'hF8) == 8'hF0) begin
      kind = LeadFour;
    end else if ((b & 8'hFC) == 8'hF8) begin
      kind = LeadFive;
    end else if ((b & 8'hFE) == 8'hFC) begin
      kind = LeadSix;
    end else begin
      kind = LeadBad;
    end
    return kind;
  endfunction

endpackage

// ===== rtl/utf8d_front.sv =====
// Front end: accepts bytes, tracks sequence state and gathers code point bits.
module utf8d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [utf8d_pkg::ByteW-1:0]   data_byte_i,
  output logic                          char_valid_o,
  output utf8d_pkg::char_t              char_o
);
  import utf8d_pkg::*;

  logic [LeftW-1:0] bytes_left_q, bytes_left_d;
  logic [CpW-1:0]   acc_q, acc_d;
  logic [CpW-1:0]   acc_shift;
  lead_kind_e       kind;

  assign acc_shift = {acc_q[CpW-7:0], data_byte_i[5:0] & ContMask[5:0]};
  assign kind      = classify_lead(data_byte_i);

  // Decode one byte
  always_comb begin
    bytes_left_d       = bytes_left_q;
    acc_d              = acc_q;
    char_valid_o       = 1'b0;
    char_o.code_point  = '0;
    char_o.decode_error = 1'b0;
    if (accept_i) begin
      if (bytes_left_q != '0) begin
        bytes_left_d = bytes_left_q - 1'b1;
        if (bytes_left_q == LeftW'(1)) begin
          char_valid_o      = 1'b1;
          char_o.code_point = acc_shift;
          acc_d             = '0;
        end else begin
          acc_d = acc_shift;
        end
      end else begin
        unique case (kind)
          LeadAscii: begin
            char_valid_o      = 1'b1;
            char_o.code_point = CpW'(data_byte_i);
          end
          LeadTwo: begin
            acc_d        = CpW'(data_byte_i & 8'h1F);
            bytes_left_d = LeftW'(1);
          end
          LeadThree: begin
            acc_d        = CpW'(data_byte_i & 8'h0F);
            bytes_left_d = LeftW'(2);
          end
          LeadFour: begin
            acc_d        = CpW'(data_byte_i & 8'h07);
            bytes_left_d = LeftW'(3);
          end
          LeadFive: begin
            acc_d        = CpW'(data_byte_i & 8'h03);
            bytes_left_d = LeftW'(4);
          end
          LeadSix: begin
            acc_d        = CpW'(data_byte_i & 8'h01);
            bytes_left_d = LeftW'(5);
          end
          default: begin
            acc_d               = '0;
            char_valid_o        = 1'b1;
            char_o.decode_error = 1'b1;
          end
        endcase
      end
    end
  end

  // Sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      acc_q        <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
    end
  end

endmodule

// ===== rtl/utf8d_fifo.sv =====
// Small queue of decoded characters between the front and the back.
module utf8d_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8d_pkg::char_t data_i,
  input  logic             pop_i,
  output utf8d_pkg::char_t data_o,
  output logic             full_o,
  output logic             empty_o
);
  import utf8d_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  char_t            mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/utf8d_back.sv =====
// Back end: batch counting, configuration register and result register.
module utf8d_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [utf8d_pkg::BatchW-1:0] batch_length_i,
  input  logic                         q_empty_i,
  input  utf8d_pkg::char_t             q_data_i,
  output logic                         q_pop_o,
  input  logic                         pop,
  output logic                         empty,
  output logic [utf8d_pkg::CpW-1:0]    code_point_o,
  output logic                         decode_error_o,
  output logic                         batch_last_o
);
  import utf8d_pkg::*;

  logic [BatchW-1:0] batch_len_q;
  logic [BatchW-1:0] count_q, count_d;
  logic [BatchW-1:0] count_inc;
  logic              out_valid_q;
  logic              mark;
  logic              take;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid_q;
  assign take      = !q_empty_i && (!out_valid_q || pop);
  assign q_pop_o   = take;
  assign count_inc = count_q + 1'b1;

  // Batch mark for the character being loaded
  always_comb begin
    mark    = 1'b0;
    count_d = count_q;
    if (take && !q_data_i.decode_error && (batch_len_q != '0)) begin
      if ((count_inc >= batch_len_q) || (count_inc == '0)) begin
        mark    = 1'b1;
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_len_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid) begin
        batch_len_q <= batch_length_i;
      end
      count_q <= count_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      code_point_o   <= q_data_i.code_point;
      decode_error_o <= q_data_i.decode_error;
      batch_last_o   <= mark;
    end
  end

endmodule

// ===== rtl/utf8_decoder_31bit_unit.sv =====
// Top level of the 31-bit legacy UTF-8 decoder.
// A byte that completes a character goes into the character queue, then into the result register.
// Throughput: one byte per cycle while full is low; bytes that do not finish a character produce no result.
// full rises only when the character queue (FifoDepth beats) and the result register are full.
// Reset: asynchronous active-low; clears sequence state, batch count, batch length and queues.
module utf8_decoder_31bit_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [utf8d_pkg::ByteW-1:0]  data_byte_i,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [utf8d_pkg::BatchW-1:0] batch_length_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [utf8d_pkg::CpW-1:0]    code_point_o,
  output logic                         decode_error_o,
  output logic                         batch_last_o
);
  import utf8d_pkg::*;

  logic  accept;
  logic  char_valid;
  char_t char_in;
  char_t char_out;
  logic  q_empty;
  logic  q_pop;

  assign accept = push && !full;

  utf8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .char_valid_o (char_valid),
    .char_o       (char_in)
  );

  utf8d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (char_valid),
    .data_i  (char_in),
    .pop_i   (q_pop),
    .data_o  (char_out),
    .full_o  (full),
    .empty_o (q_empty)
  );

  utf8d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .batch_length_i (batch_length_i),
    .q_empty_i      (q_empty),
    .q_data_i       (char_out),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .code_point_o   (code_point_o),
    .decode_error_o (decode_error_o),
    .batch_last_o   (batch_last_o)
  );

endmodule

// ===== rtl/utf8d_checker.sv =====
// Port-level checker for the decoder and its bind to the top level.
module utf8d_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [utf8d_pkg::CpW-1:0]    code_point_o,
  input logic                         decode_error_o,
  input logic                         batch_last_o
);

  // An error beat carries no code point and no batch mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && decode_error_o) |-> (code_point_o == '0) && !batch_last_o)
    else $error("error result with nonzero code point or batch mark");

  // A waiting result holds until it is popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty && $stable(code_point_o) && $stable(decode_error_o)
      && $stable(batch_last_o))
    else $error("waiting result changed");

  // Nothing waits right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result pending after reset");

  // Back pressure only when a result is already waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !empty)
    else $error("full while no result waits");

endmodule

bind utf8_decoder_31bit_unit utf8d_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .code_point_o   (code_point_o),
  .decode_error_o (decode_error_o),
  .batch_last_o   (batch_last_o)
);

// ===== tb/sv/utf8_decoder_31bit_unit_tb.sv =====
// Self-checking testbench for the 31-bit legacy UTF-8 decoder unit.
`timescale 1ns / 1ps

module utf8_decoder_31bit_unit_tb;
  import utf8d_pkg::*;

  localparam int DirRows       = 25;
  localparam int PhaseBytes    = 80;
  localparam int DrainCycles   = 8;
  localparam int HoldAtByte    = 60;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int MaxReports    = 10;

  // One decoded character as seen on the result ports
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           decode_error;
    logic           batch_last;
  } dec_char_t;

  // Directed stimulus row; typed rows carry a hand-written expectation
  typedef struct packed {
    logic [ByteW-1:0] data;
    bit               typed;
    logic [CpW-1:0]   code_point;
    logic             decode_error;
    logic             batch_last;
  } dir_row_t;

  typedef enum logic [1:0] {
    RxStream,
    RxCoin,
    RxSparse,
    RxToggle
  } rx_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [ByteW-1:0]  data_byte_i;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [BatchW-1:0] batch_length_i;
  logic              empty;
  logic              pop;
  logic [CpW-1:0]    code_point_o;
  logic              decode_error_o;
  logic              batch_last_o;

  // Decoder shadow state
  logic [LeftW-1:0]  seq_left;
  logic [CpW-1:0]    seq_acc;
  logic [BatchW-1:0] batch_cnt;
  logic [BatchW-1:0] batch_len;

  dec_char_t   pending_chars[$];
  dir_row_t    dir_rows[DirRows];
  int unsigned bytes_in, bytes_sent, chars_out, errs_out, marks_out;
  int unsigned cfg_writes, full_stalls, mismatches, idle_cycles;
  int unsigned burst_left;
  bit          hold_done;

  always #5 clk_i = ~clk_i;

  utf8_decoder_31bit_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .batch_length_i (batch_length_i),
    .empty          (empty),
    .pop            (pop),
    .code_point_o   (code_point_o),
    .decode_error_o (decode_error_o),
    .batch_last_o   (batch_last_o)
  );

  // Lead byte class from the high bits
  function automatic lead_kind_e lead_of(input logic [ByteW-1:0] b);
    lead_kind_e kind;
    casez (b)
      8'b0???????: kind = LeadAscii;
      8'b110?????: kind = LeadTwo;
      8'b1110????: kind = LeadThree;
      8'b11110???: kind = LeadFour;
      8'b111110??: kind = LeadFive;
      8'b1111110?: kind = LeadSix;
      default:     kind = LeadBad;
    endcase
    return kind;
  endfunction

  // Batch counter advance; returns the last mark
  function automatic logic batch_mark();
    if (batch_len == '0) return 1'b0;
    batch_cnt = batch_cnt + 1'b1;
    if (batch_cnt >= batch_len || batch_cnt == '0) begin
      batch_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Decode one byte; returns 1 when a character completes
  function automatic bit decode_byte(input logic [ByteW-1:0] b, output dec_char_t res);
    lead_kind_e kind;
    res = '0;
    if (seq_left != '0) begin
      // continuation: low six bits taken, top bits unchecked
      seq_acc  = {seq_acc[CpW-7:0], b[5:0]};
      seq_left = seq_left - 1'b1;
      if (seq_left != '0) return 1'b0;
      res.code_point = seq_acc;
      res.batch_last = batch_mark();
      seq_acc        = '0;
      return 1'b1;
    end
    kind = lead_of(b);
    case (kind)
      LeadAscii: begin
        res.code_point = CpW'(b);
        res.batch_last = batch_mark();
        return 1'b1;
      end
      LeadTwo: begin
        seq_acc  = CpW'(b & 8'h1F);
        seq_left = 3'd1;
      end
      LeadThree: begin
        seq_acc  = CpW'(b & 8'h0F);
        seq_left = 3'd2;
      end
      LeadFour: begin
        seq_acc  = CpW'(b & 8'h07);
        seq_left = 3'd3;
      end
      LeadFive: begin
        seq_acc  = CpW'(b & 8'h03);
        seq_left = 3'd4;
      end
      LeadSix: begin
        seq_acc  = CpW'(b & 8'h01);
        seq_left = 3'd5;
      end
      default: begin
        // invalid lead: error beat, count untouched
        seq_acc          = '0;
        res.decode_error = 1'b1;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input dec_char_t want,
                                 input dec_char_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("MISMATCH %s: exp cp=%08h err=%0b last=%0b, got cp=%08h err=%0b last=%0b",
               what, want.code_point, want.decode_error, want.batch_last,
               got.code_point, got.decode_error, got.batch_last);
    end
  endtask

  // Monitor: config beats, byte beats, result beats, watchdog
  always @(posedge clk_i) begin
    dec_char_t want, got, typed_char;
    bit        produced;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        batch_len = batch_length_i;
        cfg_writes++;
      end
      if (push && full) full_stalls++;
      if (push && !full) begin
        produced = decode_byte(data_byte_i, want);
        if (bytes_in < DirRows && dir_rows[bytes_in].typed) begin
          typed_char = {dir_rows[bytes_in].code_point, dir_rows[bytes_in].decode_error,
                        dir_rows[bytes_in].batch_last};
          if (!produced || want != typed_char) report_mismatch("typed row", typed_char, want);
          want     = typed_char;
          produced = 1'b1;
        end
        if (produced) pending_chars.push_back(want);
        bytes_in++;
      end
      if (pop && !empty) begin
        got = {code_point_o, decode_error_o, batch_last_o};
        chars_out++;
        if (decode_error_o) errs_out++;
        if (batch_last_o) marks_out++;
        if (pending_chars.size() == 0) begin
          report_mismatch("unexpected beat", '0, got);
        end else begin
          want = pending_chars.pop_front();
          if (got != want) report_mismatch("result", want, got);
        end
      end
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                   idle_cycles, pending_chars.size());
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Receiver: changing pop patterns, one long hold-off mid-run
  initial begin
    rx_mode_e    rx_mode;
    int unsigned rx_left;
    pop <= 1'b0;
    rx_mode = RxStream;
    rx_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && bytes_in >= HoldAtByte) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
          RxStream: pop <= 1'b1;
          RxCoin:   pop <= 1'($urandom);
          RxSparse: pop <= ($urandom_range(0, 3) == 0);
          default:  pop <= ~pop;
        endcase
      end
    end
  end

  // Offer one byte and wait for its beat; bursts with random gaps
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    burst_left--;
    bytes_sent++;
  endtask

  // Mostly well-formed sequences with random payload, some noise and cut sequences
  task automatic send_random_char();
    int unsigned      pick, len;
    logic [ByteW-1:0] lead;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_byte(ByteW'($urandom));
      return;
    end
    if (pick < 16) begin
      case ($urandom_range(0, 2))
        0:       send_byte({2'b10, 6'($urandom)});
        1:       send_byte(8'hFE);
        default: send_byte(8'hFF);
      endcase
      return;
    end
    len = $urandom_range(1, 6);
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      4:       lead = {5'b11110, 3'($urandom)};
      5:       lead = {6'b111110, 2'($urandom)};
      default: lead = {7'b1111110, 1'($urandom)};
    endcase
    send_byte(lead);
    // cut sequence: next lead lands in continuation position
    if (pick < 24) len = $urandom_range(1, len);
    for (int i = 1; i < len; i++) begin
      send_byte({2'b10, 6'($urandom)});
    end
  endtask

  // Batch length write, only once the decoder has drained
  task automatic write_batch_length(input logic [BatchW-1:0] len);
    push <= 1'b0;
    // settle first so the last byte's result is already queued in the shadow model
    repeat (DrainCycles) @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
    cfg_valid      <= 1'b1;
    batch_length_i <= len;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [BatchW-1:0] phase_len[8];
    int unsigned       phase_end;
    rst_ni         <= 1'b0;
    push           <= 1'b0;
    data_byte_i    <= '0;
    cfg_valid      <= 1'b0;
    batch_length_i <= '0;
    seq_left  = '0;
    seq_acc   = '0;
    batch_cnt = '0;
    batch_len = '0;
    // 65535 lets the count grow, then 3 lands below it
    phase_len = '{16'd1, 16'd4, 16'd7, 16'd2, 16'd65535, 16'd3, 16'd0, 16'd1};
    // extremes, every lead class, invalid leads, unchecked continuations
    dir_rows = '{
      '{8'h00, 1'b1, 31'h0,        1'b0, 1'b0},
      '{8'h7F, 1'b1, 31'h7F,       1'b0, 1'b0},
      '{8'h80, 1'b1, 31'h0,        1'b1, 1'b0},
      '{8'hFE, 1'b1, 31'h0,        1'b1, 1'b0},
      '{8'hFF, 1'b1, 31'h0,        1'b1, 1'b0},
      '{8'hDF, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b1, 31'h7FF,      1'b0, 1'b0},
      '{8'hE0, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'h80, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'h80, 1'b1, 31'h0,        1'b0, 1'b0},
      '{8'hF7, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b1, 31'h1FFFFF,   1'b0, 1'b0},
      '{8'hF8, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'h00, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hC0, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'h7F, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hFF, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hFD, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b0, 31'h0,        1'b0, 1'b0},
      '{8'hBF, 1'b1, 31'h7FFFFFFF, 1'b0, 1'b0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed bytes, reset batch length (never marks)
    for (int r = 0; r < DirRows; r++) begin
      send_byte(dir_rows[r].data);
    end

    // random phases, one batch length each
    foreach (phase_len[p]) begin
      write_batch_length(phase_len[p]);
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) send_random_char();
    end

    // drain and settle
    push <= 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);

    $display("Run: %0d bytes in, %0d results out (%0d decode errors, %0d batch marks)",
             bytes_in, chars_out, errs_out, marks_out);
    $display("Run: %0d batch length writes, %0d cycles with input held off by full",
             cfg_writes, full_stalls);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, pending_chars.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
